@@ hw/rtl/cbsc_pkg.sv @@
// Shared types and constants for the cassette bit serializer with CRC.
package cbsc_pkg;

  localparam int unsigned MAX_RUN_DEFAULT = 64;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [7:0]  HALF_PERIOD_RESET = 8'd12;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned RLEN_W = 7;
  localparam int unsigned SAMP_W = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_RUN    = 2'd0,
    REQ_BYTE   = 2'd1,
    REQ_CRC    = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  // Serial CRC control, one data bit per cycle while fold is set
  typedef struct packed {
    logic clear;
    logic fold;
    logic din;
  } crc_ctl_t;

  // One line bit handed to the output stage
  typedef struct packed {
    logic line_bit;
    logic last;
  } bit_beat_t;

endpackage

@@ hw/rtl/cassette_bit_serializer_crc.sv @@
// Top level: pulse-width tape bit serializer with serial CRC-16 and output register.
//
// Each request beat becomes a stream of line-bit beats, one per cycle while the
// output is not stalled: a run request gives run_length bits (saturated to
// MAX_RUN, none for zero), a byte request gives nine (LSB first, stop bit 1), a
// CRC request gives eighteen. The sequencer takes a request only when idle, so
// it accepts no new request until the last bit of the previous one is handed
// on; the shift register and the bit-serial CRC unit move one line bit and one
// CRC bit per cycle while not stalled. high_samples is half_period_samples
// for a 0 and twice that for a 1; write the register only while idle.
module cassette_bit_serializer_crc #(
  parameter int unsigned MAX_RUN = cbsc_pkg::MAX_RUN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // half_period_samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] run_value, [7:1] run_length, [15:8] data_byte, [16] crc_restart, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,    // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [0] line_bit, [9:1] high_samples, [15:10] zero
  output logic        m_axis_tlast     // last
);

  logic                 [7:0] half_period;
  logic                [15:0] crc;
  cbsc_pkg::crc_ctl_t         crc_ctl;
  cbsc_pkg::bit_beat_t        beat;
  logic                       beat_valid;
  logic                       step;
  logic                       out_bit;
  logic                       out_last;
  logic [cbsc_pkg::SAMP_W-1:0] out_samp;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= cbsc_pkg::HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      half_period <= cfg_wr_data;
    end
  end

  // advance the sequencer whenever the output register is free or draining
  assign step = !m_axis_tvalid || m_axis_tready;

  cbsc_seq #(
    .MAX_RUN (MAX_RUN)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_axis_tvalid),
    .req_ready   (s_axis_tready),
    .req_type    (s_axis_tuser),
    .run_value   (s_axis_tdata[0]),
    .run_length  (s_axis_tdata[7:1]),
    .data_byte   (s_axis_tdata[15:8]),
    .crc_restart (s_axis_tdata[16]),
    .crc         (crc),
    .crc_ctl     (crc_ctl),
    .step        (step),
    .beat_valid  (beat_valid),
    .beat        (beat)
  );

  cbsc_crc u_crc (
    .clk (clk),
    .rst (rst),
    .ctl (crc_ctl),
    .crc (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (beat_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_valid) begin
      out_bit  <= beat.line_bit;
      out_last <= beat.last;
      out_samp <= beat.line_bit ? {half_period, 1'b0} : {1'b0, half_period};
    end
  end

  assign m_axis_tdata = {6'd0, out_samp, out_bit};
  assign m_axis_tlast = out_last;

endmodule

@@ hw/rtl/cbsc_crc.sv @@
// Bit-serial reflected CRC-16 register, one data bit folded per cycle while fold is set.
module cbsc_crc (
  input  logic                clk,
  input  logic                rst,
  input  cbsc_pkg::crc_ctl_t  ctl,
  output logic [15:0]         crc
);

  logic [15:0] crc_next;
  logic        fb;

  always_comb begin
    fb       = crc[0] ^ ctl.din;
    crc_next = crc;
    if (ctl.clear) begin
      crc_next = cbsc_pkg::CRC_INIT;
    end else if (ctl.fold) begin
      crc_next = {1'b0, crc[15:1]} ^ (fb ? cbsc_pkg::CRC_POLY : 16'h0000);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= cbsc_pkg::CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

@@ hw/rtl/cbsc_seq.sv @@
// Request sequencer: shifts runs and framed bytes out one line bit per cycle while step is high.
module cbsc_seq #(
  parameter int unsigned MAX_RUN = cbsc_pkg::MAX_RUN_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [cbsc_pkg::REQ_W-1:0]    req_type,
  input  logic                          run_value,
  input  logic [cbsc_pkg::RLEN_W-1:0]   run_length,
  input  logic [7:0]                    data_byte,
  input  logic                          crc_restart,
  input  logic [15:0]                   crc,
  output cbsc_pkg::crc_ctl_t            crc_ctl,
  input  logic                          step,
  output logic                          beat_valid,
  output cbsc_pkg::bit_beat_t           beat
);

  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_FRAME = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [RUN_W-1:0] cnt, cnt_next;
  logic             val, val_next;
  logic [8:0]       sh, sh_next;
  logic [3:0]       idx, idx_next;
  logic             pend, pend_next;
  logic [7:0]       hi, hi_next;
  logic [cbsc_pkg::RLEN_W-1:0] run_sat;
  logic             accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign run_sat   = (run_length > cbsc_pkg::RLEN_W'(MAX_RUN))
                   ? cbsc_pkg::RLEN_W'(MAX_RUN) : run_length;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    val_next   = val;
    sh_next    = sh;
    idx_next   = idx;
    pend_next  = pend;
    hi_next    = hi;
    crc_ctl    = '0;
    beat_valid = 1'b0;
    beat       = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cbsc_pkg::req_t'(req_type))
            cbsc_pkg::REQ_RUN: begin
              val_next = run_value;
              cnt_next = RUN_W'(run_sat);
              if (run_sat != '0) state_next = S_RUN;
            end
            cbsc_pkg::REQ_BYTE: begin
              sh_next       = {1'b1, data_byte};
              idx_next      = '0;
              pend_next     = 1'b0;
              crc_ctl.clear = crc_restart;
              state_next    = S_FRAME;
            end
            cbsc_pkg::REQ_CRC: begin
              // snapshot: high byte held aside while the low byte folds
              sh_next    = {1'b1, crc[7:0]};
              hi_next    = crc[15:8];
              idx_next   = '0;
              pend_next  = 1'b1;
              state_next = S_FRAME;
            end
            cbsc_pkg::REQ_UNUSED: begin
              state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RUN: begin
        if (step) begin
          beat_valid    = 1'b1;
          beat.line_bit = val;
          beat.last     = (cnt == RUN_W'(1));
          cnt_next      = cnt - RUN_W'(1);
          if (cnt == RUN_W'(1)) state_next = S_IDLE;
        end
      end
      S_FRAME: begin
        if (step) begin
          beat_valid    = 1'b1;
          beat.line_bit = sh[0];
          beat.last     = (idx == 4'd8) && !pend;
          // data bits fold into the CRC, the stop bit does not
          crc_ctl.fold  = (idx != 4'd8);
          crc_ctl.din   = sh[0];
          sh_next       = {1'b0, sh[8:1]};
          idx_next      = idx + 4'd1;
          if (idx == 4'd8) begin
            if (pend) begin
              sh_next   = {1'b1, hi};
              idx_next  = '0;
              pend_next = 1'b0;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    sh  <= sh_next;
    hi  <= hi_next;
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench for the cassette bit serializer: stream driver, predictor and line-bit checker.
module tb_top;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [1:0]  user;
    logic [23:0] data;
  } req_beat_t;

  typedef struct packed {
    logic       lvl;
    logic [8:0] high_samples;
    logic       last;
  } line_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  cassette_bit_serializer_crc u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state
  logic [15:0] tape_crc = cbsc_pkg::CRC_INIT;
  logic [7:0]  half_period = cbsc_pkg::HALF_PERIOD_RESET;
  logic        tape_bits[$];

  req_beat_t   requests_to_send[$];
  line_beat_t  line_bits_due[$];

  int cycles = 0;
  int errors = 0;
  int requests_taken = 0;
  int bits_checked = 0;
  int settings_used = 1;
  int burst_left = 0;
  int gap_left = 0;
  req_beat_t  drv_item;
  line_beat_t due;

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ cbsc_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic append_framed(input logic [7:0] b);
    for (int k = 0; k < 8; k++)
      tape_bits.push_back(b[k]);
    tape_bits.push_back(1'b1);
  endtask

  task automatic predict_line_bits(input cbsc_pkg::req_t req, input logic [23:0] d);
    logic [6:0]  len;
    logic [15:0] saved;
    line_beat_t  lb;
    tape_bits.delete();
    case (req)
      cbsc_pkg::REQ_RUN: begin
        len = d[7:1];
        if (len > cbsc_pkg::MAX_RUN_DEFAULT) len = 7'(cbsc_pkg::MAX_RUN_DEFAULT);
        repeat (len) tape_bits.push_back(d[0]);
      end
      cbsc_pkg::REQ_BYTE: begin
        if (d[16]) tape_crc = cbsc_pkg::CRC_INIT;
        tape_crc = crc_fold(tape_crc, d[15:8]);
        append_framed(d[15:8]);
      end
      cbsc_pkg::REQ_CRC: begin
        // snapshot first; both bytes get folded back in as they go out
        saved = tape_crc;
        tape_crc = crc_fold(tape_crc, saved[7:0]);
        append_framed(saved[7:0]);
        tape_crc = crc_fold(tape_crc, saved[15:8]);
        append_framed(saved[15:8]);
      end
      default: ;
    endcase
    foreach (tape_bits[i]) begin
      lb.lvl = tape_bits[i];
      lb.high_samples = tape_bits[i] ? {half_period, 1'b0} : {1'b0, half_period};
      lb.last = (i == tape_bits.size() - 1);
      line_bits_due.push_back(lb);
    end
  endtask

  // Request builders; fields a request ignores get random junk
  function automatic req_beat_t run_req(input logic v, input logic [6:0] len);
    req_beat_t r;
    r.user = cbsc_pkg::REQ_RUN;
    r.data = {7'd0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), len, v};
    return r;
  endfunction

  function automatic req_beat_t byte_req(input logic [7:0] b, input logic restart);
    req_beat_t r;
    r.user = cbsc_pkg::REQ_BYTE;
    r.data = {7'd0, restart, b, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))};
    return r;
  endfunction

  function automatic req_beat_t other_req(input cbsc_pkg::req_t kind);
    req_beat_t r;
    r.user = kind;
    r.data = {7'd0, 17'($urandom_range(0, 131071))};
    return r;
  endfunction

  task automatic queue_traffic(input int count);
    int n;
    int nbytes;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 3) != 0) begin
        // well-formed frame: leader, sync byte with restart, payload, CRC, trailer
        requests_to_send.push_back(run_req(1'b1, 7'($urandom_range(1, 64))));
        requests_to_send.push_back(byte_req(8'($urandom_range(0, 255)), 1'b1));
        nbytes = $urandom_range(1, 6);
        repeat (nbytes)
          requests_to_send.push_back(byte_req(8'($urandom_range(0, 255)),
                                              ($urandom_range(0, 9) == 0)));
        requests_to_send.push_back(other_req(cbsc_pkg::REQ_CRC));
        requests_to_send.push_back(run_req(1'($urandom_range(0, 1)),
                                           7'($urandom_range(1, 16))));
        n += nbytes + 4;
      end else begin
        // noise: any code, any length, broken frames
        repeat (3)
          requests_to_send.push_back(other_req(cbsc_pkg::req_t'($urandom_range(0, 3))));
        n += 3;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (requests_to_send.size() != 0 || s_axis_tvalid || line_bits_due.size() != 0);
    // a trailing request with no bits leaves the sequencer idle; wait before going on
    repeat (8) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    half_period = v;
    settings_used++;
  endtask

  // Sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0 || requests_to_send.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        drv_item = requests_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= drv_item.data;
        s_axis_tuser <= drv_item.user;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern chosen by cycles[9:8]
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (cycles[9:8])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    m_axis_tready <= (cycles[2:0] == 3'd0);
        default: m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Predict on every accepted request beat
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_line_bits(cbsc_pkg::req_t'(s_axis_tuser), s_axis_tdata);
      requests_taken++;
    end
  end

  // Check every accepted line-bit beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (line_bits_due.size() == 0) begin
        report_mismatch($sformatf("line bit beat with nothing expected, tdata %h",
                                  m_axis_tdata));
      end else begin
        due = line_bits_due.pop_front();
        bits_checked++;
        if (m_axis_tdata[0] !== due.lvl)
          report_mismatch($sformatf("line_bit %b, expected %b", m_axis_tdata[0], due.lvl));
        if (m_axis_tdata[9:1] !== due.high_samples)
          report_mismatch($sformatf("high_samples %0d, expected %0d",
                                    m_axis_tdata[9:1], due.high_samples));
        if (m_axis_tlast !== due.last)
          report_mismatch($sformatf("last %b, expected %b", m_axis_tlast, due.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d line bits outstanding", line_bits_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: run extremes, zero and overlong runs, byte extremes, CRC, unused code
    requests_to_send.push_back(run_req(1'b0, 7'd1));
    requests_to_send.push_back(run_req(1'b1, 7'd64));
    requests_to_send.push_back(run_req(1'b1, 7'd0));
    requests_to_send.push_back(run_req(1'b1, 7'd127));
    requests_to_send.push_back(run_req(1'b0, 7'd65));
    requests_to_send.push_back(byte_req(8'h00, 1'b1));
    requests_to_send.push_back(byte_req(8'hFF, 1'b0));
    requests_to_send.push_back(byte_req(8'hA5, 1'b0));
    requests_to_send.push_back(other_req(cbsc_pkg::REQ_CRC));
    requests_to_send.push_back(other_req(cbsc_pkg::REQ_CRC));
    requests_to_send.push_back(other_req(cbsc_pkg::REQ_UNUSED));
    requests_to_send.push_back(byte_req(8'h80, 1'b1));
    requests_to_send.push_back(byte_req(8'h01, 1'b0));
    requests_to_send.push_back(other_req(cbsc_pkg::REQ_CRC));
    requests_to_send.push_back(other_req(cbsc_pkg::REQ_UNUSED));
    requests_to_send.push_back(run_req(1'b0, 7'd0));
    requests_to_send.push_back(run_req(1'b1, 7'd2));
    requests_to_send.push_back(byte_req(8'h5A, 1'b1));
    requests_to_send.push_back(other_req(cbsc_pkg::REQ_CRC));
    wait_idle();

    write_half_period(8'd255);
    queue_traffic(36);
    wait_idle();

    write_half_period(8'd1);
    queue_traffic(36);
    wait_idle();

    // zero half period: every bit reports zero samples
    write_half_period(8'd0);
    queue_traffic(36);
    wait_idle();

    write_half_period(8'($urandom_range(2, 254)));
    queue_traffic(36);
    wait_idle();

    $display("covered %0d requests and %0d line bits over %0d half-period settings",
             requests_taken, bits_checked, settings_used);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
